@@ rtl/core/cbp_pkg.sv @@
// Shared types, constants and helper functions of the coefficient bit packer.
`timescale 1ns / 1ps

package cbp_pkg;

  localparam int unsigned CoeffW     = 20;  // coefficient and offset width
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AccW       = 32;  // bit accumulator
  localparam int unsigned CntW       = 5;   // bits held in the accumulator
  localparam int unsigned WidthW     = 5;   // field width register
  localparam int unsigned MinWidth   = 1;
  localparam int unsigned MaxWidth   = 20;
  localparam int unsigned ResetWidth = 13;
  localparam int unsigned MaxResults = 4;   // per transaction in unpack mode
  localparam int unsigned ResIdxW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned QueueDepth = 2;
  // A byte is appended only while it still fits below bit 31.
  localparam int unsigned AppendLimit = AccW - ByteW - 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UNPACK_MODE  = 2'd0,
    REG_FIELD_WIDTH  = 2'd1,
    REG_OFFSET_VALUE = 2'd2,
    REG_SIGN_EXTEND  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_in;
    logic [ByteW-1:0]         byte_in;
    logic                     poly_end;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]         byte_out;
    logic signed [CoeffW-1:0] coeff_out;
    logic                     run_last;
  } out_item_t;

  // Decoded configuration seen by the front and the back.
  typedef struct packed {
    logic              unpack_mode;
    logic [WidthW-1:0] width;
    logic [CoeffW-1:0] mask;
    logic [CoeffW-1:0] offset;
    logic              sign_extend;
  } cfg_t;

  // Entry of the queue between front and back: a masked field (pack)
  // or a byte in the low bits (unpack).
  typedef struct packed {
    logic [CoeffW-1:0] bits;
    logic              poly_end;
  } work_t;

  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] fw);
    if (fw < WidthW'(MinWidth)) begin
      return WidthW'(MinWidth);
    end
    if (fw > WidthW'(MaxWidth)) begin
      return WidthW'(MaxWidth);
    end
    return fw;
  endfunction

  function automatic logic [CoeffW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [CoeffW-1:0] m;
    for (int i = 0; i < CoeffW; i++) begin
      m[i] = (WidthW'(i) < w);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/cbp_fifo.sv @@
// Small flip-flop queue used between the packer stages.
`timescale 1ns / 1ps

module cbp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy above depth");

endmodule

@@ rtl/core/cbp_front.sv @@
// Front stage: classify an incoming transaction into a queue entry.
`timescale 1ns / 1ps

module cbp_front
  import cbp_pkg::*;
(
  input  cfg_t     cfg_i,
  input  in_item_t in_item_i,
  output work_t    work_o
);

  logic [CoeffW-1:0] biased;

  // Bias and cut the coefficient here so the back only shifts and merges.
  assign biased = $unsigned(in_item_i.coeff_in) + cfg_i.offset;

  always_comb begin
    work_o.poly_end = in_item_i.poly_end;
    if (cfg_i.unpack_mode) begin
      work_o.bits = CoeffW'(in_item_i.byte_in);
    end else begin
      work_o.bits = biased & cfg_i.mask;
    end
  end

endmodule

@@ rtl/core/cbp_back.sv @@
// Back stage: bit accumulator that merges queue entries and emits results.
`timescale 1ns / 1ps

module cbp_back
  import cbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      clear_i,
  input  logic      q_empty_i,
  input  work_t     q_data_i,
  output logic      q_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t out_item_o
);

  localparam logic [CntW-1:0]    ByteCnt = CntW'(ByteW);
  localparam logic [CntW-1:0]    AppLim  = CntW'(AppendLimit);
  localparam logic [ResIdxW-1:0] LastIdx = ResIdxW'(MaxResults - 1);

  logic [AccW-1:0]    acc_q, acc_d, acc_s, base_acc, m_acc;
  logic [CntW-1:0]    cnt_q, cnt_d, cnt_s, base_cnt, m_cnt;
  logic               busy_q, busy_d, end_q, end_d;
  logic [ResIdxW-1:0] idx_q, idx_d;
  logic [CoeffW-1:0]  field, coeff;
  logic               top_bit, more_s, emit, base_free, load, has_m;

  // Current result and the state left behind once it has gone.
  always_comb begin
    field   = acc_q[CoeffW-1:0] & cfg_i.mask;
    top_bit = |(field & (cfg_i.mask ^ (cfg_i.mask >> 1)));
    if (cfg_i.sign_extend) begin
      coeff = top_bit ? (field | ~cfg_i.mask) : field;
    end else begin
      coeff = field - cfg_i.offset;
    end

    if (cfg_i.unpack_mode) begin
      acc_s  = acc_q >> cfg_i.width;
      cnt_s  = cnt_q - cfg_i.width;
      more_s = (cnt_s >= cfg_i.width) && (idx_q != LastIdx);
    end else if (cnt_q >= ByteCnt) begin
      acc_s  = acc_q >> ByteW;
      cnt_s  = cnt_q - ByteCnt;
      more_s = (cnt_s >= ByteCnt) || (end_q && (cnt_s != '0));
    end else begin
      // zero-padded flush byte
      acc_s  = '0;
      cnt_s  = '0;
      more_s = 1'b0;
    end
    // drop leftover bits at the end of a polynomial
    if (!more_s && end_q) begin
      acc_s = '0;
      cnt_s = '0;
    end
  end

  assign emit      = busy_q && !out_full_i;
  assign base_free = !busy_q || (emit && !more_s);
  assign load      = base_free && !q_empty_i;
  assign q_pop_o   = load;
  assign base_acc  = busy_q ? acc_s : acc_q;
  assign base_cnt  = busy_q ? cnt_s : cnt_q;

  // Merge the next entry on top of the bits still held.
  always_comb begin
    m_acc = base_acc;
    m_cnt = base_cnt;
    if (cfg_i.unpack_mode) begin
      if (base_cnt <= AppLim) begin
        m_acc = base_acc | (AccW'(q_data_i.bits[ByteW-1:0]) << base_cnt);
        m_cnt = base_cnt + ByteCnt;
      end
      has_m = (m_cnt >= cfg_i.width);
    end else begin
      m_acc = base_acc | (AccW'(q_data_i.bits) << base_cnt);
      m_cnt = base_cnt + cfg_i.width;
      has_m = (m_cnt >= ByteCnt) || (q_data_i.poly_end && (m_cnt != '0));
    end
  end

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    end_d  = end_q;
    idx_d  = idx_q;
    if (clear_i) begin
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b0;
    end else if (load) begin
      busy_d = has_m;
      end_d  = q_data_i.poly_end;
      idx_d  = '0;
      if (!has_m && q_data_i.poly_end) begin
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = m_acc;
        cnt_d = m_cnt;
      end
    end else if (emit) begin
      acc_d  = acc_s;
      cnt_d  = cnt_s;
      busy_d = more_s;
      idx_d  = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      end_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      end_q  <= end_d;
      idx_q  <= idx_d;
    end
  end

  assign out_push_o           = emit;
  assign out_item_o.byte_out  = cfg_i.unpack_mode ? '0 : acc_q[ByteW-1:0];
  assign out_item_o.coeff_out = cfg_i.unpack_mode ? $signed(coeff) : '0;
  assign out_item_o.run_last  = !more_s;

  a_pack_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cfg_i.unpack_mode |-> (cnt_q >= ByteCnt) || (end_q && (cnt_q != '0)))
    else $error("pack result pending without bits to send");

  a_pack_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !cfg_i.unpack_mode |-> cnt_q < ByteCnt)
    else $error("whole byte left in accumulator while idle");

  a_unpack_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && cfg_i.unpack_mode && (idx_q == LastIdx) |-> out_item_o.run_last)
    else $error("more results than allowed for one transaction");

endmodule

@@ rtl/core/coeff_bit_packer_top.sv @@
// Top level of the coefficient bit packer: ports, configuration, stage wiring.
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------
// input    | push, full              | in_item_i  (coeff_in, byte_in, poly_end)
// result   | pop, empty              | out_item_o (byte_out, coeff_out, run_last)
// config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// In the back stage the bit accumulator releases one result per cycle while
// the result queue has room, and merges the next entry in the cycle of the
// previous one's last result, so a 20-bit pack gives up to 3 results, or 4
// when the end of a polynomial adds a padded byte.
// Results reach the ports through the input queue, accumulator and result queue.
// Reset clears the queues, the accumulator and restores the register defaults.
// A full result queue stalls the back stage; the input queue keeps accepting
// until it fills, so either side can stall without starving the other.

module coeff_bit_packer_top
  import cbp_pkg::*;
#(
  parameter int unsigned InQueueDepth  = QueueDepth,
  parameter int unsigned OutQueueDepth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input transactions
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  // result transactions
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic              unpack_mode_q, sign_ext_q;
  logic [WidthW-1:0] field_width_q;
  logic [CoeffW-1:0] offset_q;
  logic              clear;
  cfg_t              cfg;

  work_t             front_work, q_work;
  logic              q_empty, q_pop;
  logic              out_push, out_full;
  out_item_t         back_item;

  // Register file: write only, taken at once. A mode write also flushes
  // the accumulator so the new direction starts from an empty bit stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unpack_mode_q <= 1'b0;
      field_width_q <= WidthW'(ResetWidth);
      offset_q      <= '0;
      sign_ext_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_UNPACK_MODE:  unpack_mode_q <= cfg_data_i[0];
        REG_FIELD_WIDTH:  field_width_q <= cfg_data_i[WidthW-1:0];
        REG_OFFSET_VALUE: offset_q      <= cfg_data_i[CoeffW-1:0];
        REG_SIGN_EXTEND:  sign_ext_q    <= cfg_data_i[0];
      endcase
    end
  end

  assign clear = cfg_we_i && (reg_idx_e'(cfg_idx_i) == REG_UNPACK_MODE);

  // Clamp the width once here; both stages use the decoded form.
  always_comb begin
    cfg.unpack_mode = unpack_mode_q;
    cfg.width       = eff_width(field_width_q);
    cfg.mask        = width_mask(cfg.width);
    cfg.offset      = offset_q;
    cfg.sign_extend = sign_ext_q;
  end

  cbp_front u_front (
    .cfg_i     (cfg),
    .in_item_i (in_item_i),
    .work_o    (front_work)
  );

  // Queue that decouples accepting from packing.
  cbp_fifo #(
    .Width ($bits(work_t)),
    .Depth (InQueueDepth)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_work),
    .empty_o (q_empty)
  );

  cbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .clear_i    (clear),
    .q_empty_i  (q_empty),
    .q_data_i   (q_work),
    .q_pop_o    (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (back_item)
  );

  // Result queue: hold finished results while the consumer stalls.
  cbp_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutQueueDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

@@ verif/cbp_tb_pkg.sv @@
// Scoreboard class for the coefficient bit packer: bit-level predictor and result check.
`timescale 1ns / 1ps

package cbp_tb_pkg;
  import cbp_pkg::*;

  class packer_scoreboard;
    // register copy
    logic              unpack_sel;
    logic [4:0]        width_reg;
    logic [19:0]       offset_reg;
    logic              sext_reg;
    // bit accumulator copy
    logic [31:0]       held_bits;
    logic [4:0]        held_count;
    out_item_t         awaited_results[$];
    int unsigned       mismatches;
    int unsigned       results_checked;
    int unsigned       items_seen;

    localparam int unsigned ByteFitLimit = 23;

    function new();
      unpack_sel      = 1'b0;
      width_reg       = 5'd13;
      offset_reg      = '0;
      sext_reg        = 1'b1;
      held_bits       = '0;
      held_count      = '0;
      mismatches      = 0;
      results_checked = 0;
      items_seen      = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [19:0] data);
      case (idx)
        REG_UNPACK_MODE: begin
          // a mode change empties the accumulator
          unpack_sel = data[0];
          held_bits  = '0;
          held_count = '0;
        end
        REG_FIELD_WIDTH:  width_reg  = data[4:0];
        REG_OFFSET_VALUE: offset_reg = data;
        REG_SIGN_EXTEND:  sext_reg   = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned lane_width();
      if (width_reg == 5'd0) return 1;
      if (width_reg > 5'd20) return 20;
      return width_reg;
    endfunction

    // Work out the bytes or coefficients that one accepted item releases.
    function void note_item(in_item_t it);
      int unsigned w;
      int unsigned cnt;
      logic [31:0] mask;
      logic [31:0] val;
      logic [31:0] f;
      logic [31:0] v;
      logic [63:0] acc;
      out_item_t   r;
      out_item_t   batch[$];
      w    = lane_width();
      mask = (32'd1 << w) - 32'd1;
      acc  = {32'd0, held_bits};
      cnt  = held_count;
      items_seen++;
      if (!unpack_sel) begin
        val = ({12'd0, it.coeff_in} + {12'd0, offset_reg}) & mask;
        acc = acc | ({32'd0, val} << cnt);
        cnt = cnt + w;
        while (cnt >= 8 && batch.size() < MaxResults) begin
          r = '0;
          r.byte_out = acc[7:0];
          batch.push_back(r);
          acc = acc >> 8;
          cnt = cnt - 8;
        end
        // flush a zero-padded partial byte on the last coefficient
        if (it.poly_end && cnt > 0 && batch.size() < MaxResults) begin
          r = '0;
          r.byte_out = acc[7:0];
          batch.push_back(r);
          acc = '0;
          cnt = 0;
        end
      end else begin
        // drop the byte when it no longer fits, drain only
        if (cnt <= ByteFitLimit) begin
          acc = acc | ({56'd0, it.byte_in} << cnt);
          cnt = cnt + 8;
        end
        while (cnt >= w && batch.size() < MaxResults) begin
          f = acc[31:0] & mask;
          if (sext_reg) begin
            v = f[w-1] ? (f | ~mask) : f;
          end else begin
            v = f - {12'd0, offset_reg};
          end
          r = '0;
          r.coeff_out = v[19:0];
          batch.push_back(r);
          acc = acc >> w;
          cnt = cnt - w;
        end
        if (it.poly_end) begin
          acc = '0;
          cnt = 0;
        end
      end
      held_bits  = acc[31:0];
      held_count = cnt[4:0];
      if (batch.size() > 0) begin
        batch[batch.size()-1].run_last = 1'b1;
      end
      foreach (batch[i]) awaited_results.push_back(batch[i]);
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 100) begin
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
      end
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_results.size() == 0) begin
        report("result with nothing outstanding", 32'(got), 32'd0);
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      if (got.byte_out !== want.byte_out) begin
        report("byte_out", 32'(got.byte_out), 32'(want.byte_out));
      end
      if (got.coeff_out !== want.coeff_out) begin
        report("coeff_out", {12'd0, got.coeff_out}, {12'd0, want.coeff_out});
      end
      if (got.run_last !== want.run_last) begin
        report("run_last", 32'(got.run_last), 32'(want.run_last));
      end
    endtask

    task check_drained();
      if (awaited_results.size() != 0) begin
        report("results never produced", awaited_results.size(), 32'd0);
      end
    endtask
  endclass

endpackage

@@ verif/tb.sv @@
// Testbench top for the coefficient bit packer: clock, reset, drivers and stimulus.
`timescale 1ns / 1ps

module tb;
  import cbp_pkg::*;
  import cbp_tb_pkg::*;

  localparam int unsigned IdlePct     = 34;      // chance of an idle cycle per side
  localparam int unsigned DrainCycles = 16;      // margin for items that release nothing
  localparam int unsigned CycleLimit  = 300000;  // far above the slowest correct run

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  packer_scoreboard    sb = new();
  logic                calm;        // suppress idling on both sides
  int unsigned         cycles;
  int unsigned         phases;

  coeff_bit_packer_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 8 ns clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: abandon the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Outputs of the block only move
  // after the edge, so what is read here is the value the edge acted on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_item(in_item);
      end
      if (pop && !empty) begin
        sb.check_result(out_item);
      end
    end
  end

  // Result side: raise pop at random, or hold it high through calm stretches.
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      pop <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Offer one input transaction, preceded by a random run of idle cycles.
  // Enter and leave at a falling edge so push is assigned once per step.
  task automatic send_item(logic [19:0] coeff, logic [7:0] byte_val, logic last);
    in_item_t it;
    it.coeff_in = coeff;
    it.byte_in  = byte_val;
    it.poly_end = last;
    if (!calm && $urandom_range(99) < IdlePct) begin
      push <= 1'b0;
      do begin
        @(negedge clk_i);
      end while ($urandom_range(99) < IdlePct);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop push and wait until every awaited result has come, then let the
  // pipeline empty of items that release nothing.
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic cfg_write(reg_idx_e idx, logic [19:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [19:0] pick_coeff();
    case ($urandom_range(15))
      0:       return 20'h80000;
      1:       return 20'h7FFFF;
      2:       return 20'h00000;
      3:       return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random phase: fresh settings, then mostly well-formed polynomials
  // with random content, the rest loose items with poly_end at random.
  task automatic random_phase(int unsigned items);
    int unsigned count;
    int unsigned len;
    logic        loose;
    logic [19:0] w;
    logic [19:0] off;
    settle();
    phases++;
    case ($urandom_range(9))
      0:       w = 20'd0;
      1:       w = 20'($urandom_range(21, 31));
      2:       w = 20'd1;
      3:       w = 20'd20;
      default: w = 20'($urandom_range(1, 20));
    endcase
    case ($urandom_range(5))
      0:       off = 20'd0;
      1:       off = 20'd524288;
      2:       off = 20'hFFFFF;
      default: off = 20'($urandom);
    endcase
    // skip the mode write now and then so leftover bits carry across phases
    if ($urandom_range(3) != 0) cfg_write(REG_UNPACK_MODE, 20'($urandom_range(1)));
    cfg_write(REG_FIELD_WIDTH, w);
    if ($urandom_range(1)) cfg_write(REG_OFFSET_VALUE, off);
    if ($urandom_range(1)) cfg_write(REG_SIGN_EXTEND, 20'($urandom_range(1)));
    count = 0;
    while (count < items) begin
      len   = $urandom_range(1, 16);
      loose = ($urandom_range(99) < 20);
      for (int unsigned i = 0; i < len && count < items; i++) begin
        send_item(pick_coeff(), pick_byte(),
                  loose ? 1'($urandom_range(1)) : (i == len - 1));
        count++;
      end
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    push     = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = REG_UNPACK_MODE;
    cfg_data = '0;
    calm     = 1'b0;
    phases   = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Pack at full width with an offset that wraps the sum; sign_extend is
    // cleared to show it has no say over packing.
    settle();
    phases++;
    cfg_write(REG_FIELD_WIDTH, 20'd20);
    cfg_write(REG_OFFSET_VALUE, 20'd524288);
    cfg_write(REG_SIGN_EXTEND, 20'd0);
    send_item(20'h7FFFF, 8'hFF, 1'b0);
    send_item(20'h80000, 8'h00, 1'b0);
    send_item(20'hFFFFF, 8'hFF, 1'b0);
    send_item(20'h00000, 8'h00, 1'b1);

    // Width zero behaves as one bit; end of polynomial pads a partial byte.
    settle();
    phases++;
    cfg_write(REG_FIELD_WIDTH, 20'd0);
    cfg_write(REG_OFFSET_VALUE, 20'd0);
    send_item(20'h00001, 8'h00, 1'b0);
    send_item(20'h00000, 8'h00, 1'b0);
    send_item(20'hFFFFF, 8'h00, 1'b1);

    // End on a byte boundary sends no padding; leave four bits behind for
    // the mode change to discard.
    settle();
    phases++;
    cfg_write(REG_FIELD_WIDTH, 20'd4);
    cfg_write(REG_OFFSET_VALUE, 20'hFFFFF);
    send_item(20'h00003, 8'h00, 1'b0);
    send_item(20'h7FFF5, 8'h00, 1'b1);
    send_item(20'h0000A, 8'h00, 1'b0);

    // Unpack with an oversized width (acts as twenty) and sign extension:
    // all ones first, then the most negative field.
    settle();
    phases++;
    cfg_write(REG_UNPACK_MODE, 20'd1);
    cfg_write(REG_FIELD_WIDTH, 20'd31);
    cfg_write(REG_SIGN_EXTEND, 20'd1);
    send_item(20'h00000, 8'hFF, 1'b0);
    send_item(20'hFFFFF, 8'hFF, 1'b0);
    send_item(20'h00000, 8'h0F, 1'b0);
    send_item(20'hFFFFF, 8'h00, 1'b0);
    send_item(20'h00000, 8'h80, 1'b1);

    // One-bit fields with an offset: four results per byte cap the drain,
    // bits pile up in the accumulator; the end discards the rest.
    settle();
    phases++;
    cfg_write(REG_FIELD_WIDTH, 20'd1);
    cfg_write(REG_SIGN_EXTEND, 20'd0);
    cfg_write(REG_OFFSET_VALUE, 20'd524288);
    repeat (5) send_item(20'h00000, 8'hFF, 1'b0);
    send_item(20'h00000, 8'h5A, 1'b1);

    // Random part; one phase runs without idling on either side.
    for (int p = 0; p < 10; p++) begin
      if (p == 4) begin
        settle();
        calm = 1'b1;
      end
      random_phase(p == 4 ? 48 : 28);
      if (p == 4) begin
        settle();
        calm = 1'b0;
      end
    end

    settle();
    sb.check_drained();
    $display("Covered %0d input transactions in %0d register settings, %0d results checked,",
             sb.items_seen, phases, sb.results_checked);
    $display("both directions, widths 0 to 31, offset and sign-extend unpacking.");
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
